>>> rtl/s16alu_pkg.sv
package s16alu_pkg;

   localparam logic [4:0] OP_SET = 5'h01;
   localparam logic [4:0] OP_ADD = 5'h02;
   localparam logic [4:0] OP_SUB = 5'h03;
   localparam logic [4:0] OP_MUL = 5'h04;
   localparam logic [4:0] OP_MLI = 5'h05;
   localparam logic [4:0] OP_DIV = 5'h06;
   localparam logic [4:0] OP_DVI = 5'h07;
   localparam logic [4:0] OP_MOD = 5'h08;
   localparam logic [4:0] OP_MDI = 5'h09;
   localparam logic [4:0] OP_AND = 5'h0a;
   localparam logic [4:0] OP_BOR = 5'h0b;
   localparam logic [4:0] OP_XOR = 5'h0c;
   localparam logic [4:0] OP_SHR = 5'h0d;
   localparam logic [4:0] OP_ASR = 5'h0e;
   localparam logic [4:0] OP_SHL = 5'h0f;
   localparam logic [4:0] OP_IFB = 5'h10;
   localparam logic [4:0] OP_IFC = 5'h11;
   localparam logic [4:0] OP_IFE = 5'h12;
   localparam logic [4:0] OP_IFN = 5'h13;
   localparam logic [4:0] OP_IFG = 5'h14;
   localparam logic [4:0] OP_IFA = 5'h15;
   localparam logic [4:0] OP_IFL = 5'h16;
   localparam logic [4:0] OP_IFU = 5'h17;
   localparam logic [4:0] OP_ADX = 5'h1a;
   localparam logic [4:0] OP_SBX = 5'h1b;
   localparam logic [4:0] OP_STI = 5'h1e;
   localparam logic [4:0] OP_STD = 5'h1f;

   localparam logic [1:0] STEP_NONE = 2'b00;
   localparam logic [1:0] STEP_INC  = 2'b01;
   localparam logic [1:0] STEP_DEC  = 2'b11;

   // quotient bits: 16 integer, 16 fraction
   localparam int DivBits      = 32;
   localparam int BitsPerStage = 2;
   localparam int DivStages    = DivBits / BitsPerStage;
   localparam int RemStage     = (DivBits / 2) / BitsPerStage - 1;

   typedef struct packed {
      logic        write_b;
      logic [15:0] b_result;
      logic        write_ex;
      logic [15:0] ex_result;
      logic        skip_next;
      logic [1:0]  index_step;
   } result_type;

   typedef struct packed {
      logic [4:0] kind;
      logic       a_zero;
      logic       neg_q;
      logic       neg_r;
   } info_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [31:0] dq;
      logic [15:0] divisor;
      logic [15:0] mod_rem;
   } div_type;

   typedef struct packed {
      result_type res;
      info_type   info;
      div_type    div;
   } pipe_type;

endpackage

>>> rtl/sixteen_bit_cpu_alu_execute.sv
// channel  dir  ports                         payload
// req      in   req_tvalid/tready/tdata/tuser  tdata: a_value, b_value, ex_in; tuser: kind
// rsp      out  rsp_tvalid/tready/tdata        tdata: write_b, b_result, write_ex,
//                                              ex_result, skip_next, index_step
//
// One item per cycle unless a held result stalls the pipe; stages: input stage,
// ALU/multiplier stage, 16 divider stages (2 quotient bits each), output register.
// Synchronous active-high reset clears all valid bits.
// The whole pipe holds while a result waits and rsp_tready is low; nothing is lost.
module sixteen_bit_cpu_alu_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // a_value[15:0], b_value[31:16], ex_in[47:32]
   input  logic [4:0]  req_tuser,   // kind[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // write_b[0], b_result[16:1], write_ex[17],
                                    // ex_result[33:18], skip_next[34],
                                    // index_step[36:35], zero[39:37]
);

   logic adv;
   logic front_valid;
   s16alu_pkg::pipe_type front_data;
   logic [s16alu_pkg::DivStages:0] dv_valid;
   s16alu_pkg::pipe_type dv_data [s16alu_pkg::DivStages+1];
   s16alu_pkg::result_type res;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   s16alu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .kind      (req_tuser),
      .a_value   (req_tdata[15:0]),
      .b_value   (req_tdata[31:16]),
      .ex_in     (req_tdata[47:32]),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   assign dv_valid[0] = front_valid;
   assign dv_data[0]  = front_data;

   for (genvar i = 0; i < s16alu_pkg::DivStages; i++) begin : g_div
      s16alu_div_step #(
         .CAPTURE_REM (i == s16alu_pkg::RemStage)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i+1]),
         .out_data  (dv_data[i+1])
      );
   end

   s16alu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid[s16alu_pkg::DivStages]),
      .in_data   (dv_data[s16alu_pkg::DivStages]),
      .out_valid (rsp_tvalid),
      .out_data  (res)
   );

   assign rsp_tdata = {3'b000, res.index_step, res.skip_next, res.ex_result,
                       res.write_ex, res.b_result, res.write_b};

endmodule

>>> rtl/s16alu_front.sv
module s16alu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [4:0]           kind,
   input  logic [15:0]          a_value,
   input  logic [15:0]          b_value,
   input  logic [15:0]          ex_in,
   output logic                 out_valid,
   output s16alu_pkg::pipe_type out_data
);

   logic        s1_valid_ff;
   logic [4:0]  s1_kind_ff;
   logic [15:0] s1_a_ff, s1_b_ff, s1_ex_ff;
   logic        s2_valid_ff;
   s16alu_pkg::pipe_type s2_data_ff, s2_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff <= kind;
         s1_a_ff    <= a_value;
         s1_b_ff    <= b_value;
         s1_ex_ff   <= ex_in;
         s2_data_ff <= s2_data_in;
      end
   end

   always_comb begin
      logic [15:0] a, b;
      logic [16:0] sum;
      logic [17:0] sum3;
      logic signed [18:0] dif3;
      logic [31:0] prod, t;
      logic signed [31:0] sprod, st;
      logic        big;
      logic [15:0] ma, mb;
      s16alu_pkg::result_type r;
      a = s1_a_ff;
      b = s1_b_ff;
      big = (a[15:5] != 11'd0);
      sum = {1'b0, b} + {1'b0, a};
      sum3 = {2'b00, b} + {2'b00, a} + {2'b00, s1_ex_ff};
      dif3 = $signed({3'b000, b}) - $signed({3'b000, a}) + $signed({3'b000, s1_ex_ff});
      prod = {16'd0, b} * {16'd0, a};
      sprod = $signed({{16{b[15]}}, b}) * $signed({{16{a[15]}}, a});
      r = '0;
      t = '0;
      st = '0;
      case (s1_kind_ff)
         s16alu_pkg::OP_SET: begin
            r.write_b = 1'b1; r.b_result = a;
         end
         s16alu_pkg::OP_ADD: begin
            r.write_b = 1'b1; r.b_result = sum[15:0];
            r.write_ex = 1'b1; r.ex_result = {15'd0, sum[16]};
         end
         s16alu_pkg::OP_SUB: begin
            r.write_b = 1'b1; r.b_result = b - a;
            r.write_ex = 1'b1; r.ex_result = (b < a) ? 16'hffff : 16'h0000;
         end
         s16alu_pkg::OP_MUL: begin
            r.write_b = 1'b1; r.b_result = prod[15:0];
            r.write_ex = 1'b1; r.ex_result = prod[31:16];
         end
         s16alu_pkg::OP_MLI: begin
            r.write_b = 1'b1; r.b_result = sprod[15:0];
            r.write_ex = 1'b1; r.ex_result = sprod[31:16];
         end
         s16alu_pkg::OP_DIV, s16alu_pkg::OP_DVI: begin
            r.write_b = 1'b1; r.write_ex = 1'b1;
         end
         s16alu_pkg::OP_MOD, s16alu_pkg::OP_MDI: begin
            r.write_b = 1'b1;
         end
         s16alu_pkg::OP_AND: begin
            r.write_b = 1'b1; r.b_result = b & a;
         end
         s16alu_pkg::OP_BOR: begin
            r.write_b = 1'b1; r.b_result = b | a;
         end
         s16alu_pkg::OP_XOR: begin
            r.write_b = 1'b1; r.b_result = b ^ a;
         end
         s16alu_pkg::OP_SHR: begin
            r.write_b = 1'b1; r.write_ex = 1'b1;
            if (!big) begin
               t = {b, 16'd0} >> a[4:0];
               r.b_result = t[31:16]; r.ex_result = t[15:0];
            end
         end
         s16alu_pkg::OP_ASR: begin
            r.write_b = 1'b1; r.write_ex = 1'b1;
            if (!big) st = $signed({b, 16'd0}) >>> a[4:0];
            else st = {32{b[15]}};
            r.b_result = st[31:16]; r.ex_result = st[15:0];
         end
         s16alu_pkg::OP_SHL: begin
            r.write_b = 1'b1; r.write_ex = 1'b1;
            if (!big) begin
               t = {16'd0, b} << a[4:0];
               r.b_result = t[15:0]; r.ex_result = t[31:16];
            end
         end
         s16alu_pkg::OP_IFB: r.skip_next = ((b & a) == 16'd0);
         s16alu_pkg::OP_IFC: r.skip_next = ((b & a) != 16'd0);
         s16alu_pkg::OP_IFE: r.skip_next = (b != a);
         s16alu_pkg::OP_IFN: r.skip_next = (b == a);
         s16alu_pkg::OP_IFG: r.skip_next = !(b > a);
         s16alu_pkg::OP_IFA: r.skip_next = !($signed(b) > $signed(a));
         s16alu_pkg::OP_IFL: r.skip_next = !(b < a);
         s16alu_pkg::OP_IFU: r.skip_next = !($signed(b) < $signed(a));
         s16alu_pkg::OP_ADX: begin
            r.write_b = 1'b1; r.b_result = sum3[15:0];
            r.write_ex = 1'b1; r.ex_result = {15'd0, (sum3[17:16] != 2'b00)};
         end
         s16alu_pkg::OP_SBX: begin
            r.write_b = 1'b1; r.b_result = dif3[15:0];
            r.write_ex = 1'b1;
            if (dif3[18]) r.ex_result = 16'hffff;
            else if (dif3[17:16] != 2'b00) r.ex_result = 16'h0001;
            else r.ex_result = 16'h0000;
         end
         s16alu_pkg::OP_STI: begin
            r.write_b = 1'b1; r.b_result = a; r.index_step = s16alu_pkg::STEP_INC;
         end
         s16alu_pkg::OP_STD: begin
            r.write_b = 1'b1; r.b_result = a; r.index_step = s16alu_pkg::STEP_DEC;
         end
         default: r = '0;
      endcase

      // signed ops divide magnitudes, sign fixed at the end
      if (s1_kind_ff == s16alu_pkg::OP_DVI || s1_kind_ff == s16alu_pkg::OP_MDI) begin
         ma = a[15] ? 16'(-a) : a;
         mb = b[15] ? 16'(-b) : b;
         s2_data_in.info.neg_q = a[15] ^ b[15];
         s2_data_in.info.neg_r = b[15];
      end else begin
         ma = a;
         mb = b;
         s2_data_in.info.neg_q = 1'b0;
         s2_data_in.info.neg_r = 1'b0;
      end
      s2_data_in.res         = r;
      s2_data_in.info.kind   = s1_kind_ff;
      s2_data_in.info.a_zero = (a == 16'd0);
      s2_data_in.div.rem     = 16'd0;
      s2_data_in.div.dq      = {mb, 16'd0};
      s2_data_in.div.divisor = ma;
      s2_data_in.div.mod_rem = 16'd0;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

>>> rtl/s16alu_div_step.sv
module s16alu_div_step #(
   parameter bit CAPTURE_REM = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  s16alu_pkg::pipe_type in_data,
   output logic                 out_valid,
   output s16alu_pkg::pipe_type out_data
);

   logic                 valid_ff;
   s16alu_pkg::pipe_type data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   always_comb begin
      logic [15:0] rem;
      logic [31:0] dq;
      logic [16:0] trial;
      rem = in_data.div.rem;
      dq  = in_data.div.dq;
      for (int k = 0; k < s16alu_pkg::BitsPerStage; k++) begin
         trial = {rem, dq[31]};
         if (trial >= {1'b0, in_data.div.divisor}) begin
            rem = 16'(trial - {1'b0, in_data.div.divisor});
            dq  = {dq[30:0], 1'b1};
         end else begin
            rem = trial[15:0];
            dq  = {dq[30:0], 1'b0};
         end
      end
      data_in         = in_data;
      data_in.div.rem = rem;
      data_in.div.dq  = dq;
      if (CAPTURE_REM) data_in.div.mod_rem = rem;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/s16alu_back.sv
module s16alu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  s16alu_pkg::pipe_type   in_data,
   output logic                   out_valid,
   output s16alu_pkg::result_type out_data
);

   logic                   valid_ff;
   s16alu_pkg::result_type data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   always_comb begin
      logic [15:0] qi, qf, rm;
      qi = in_data.div.dq[31:16];
      qf = in_data.div.dq[15:0];
      rm = in_data.div.mod_rem;
      data_in = in_data.res;
      case (in_data.info.kind)
         s16alu_pkg::OP_DIV, s16alu_pkg::OP_DVI: begin
            if (in_data.info.neg_q) begin
               qi = 16'(-qi);
               qf = 16'(-qf);
            end
            data_in.b_result  = in_data.info.a_zero ? 16'd0 : qi;
            data_in.ex_result = in_data.info.a_zero ? 16'd0 : qf;
         end
         s16alu_pkg::OP_MOD, s16alu_pkg::OP_MDI: begin
            if (in_data.info.neg_r) rm = 16'(-rm);
            data_in.b_result = in_data.info.a_zero ? 16'd0 : rm;
         end
         default: data_in = in_data.res;
      endcase
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
